// ----- rtl/core/dpfp_pkg.sv -----
// Package of shared constants and types for the device-path file-path finder.
`timescale 1ns / 1ps
`default_nettype none
package dpfp_pkg;

	// Default width of the buffer length and of the byte counters
	localparam int unsigned LENGTH_BITS_DEFAULT = 16;

	// Node header layout and the node kinds of interest
	localparam logic [7:0] TYPE_MEDIA       = 8'h04;
	localparam logic [7:0] SUBTYPE_FILEPATH = 8'h04;
	localparam logic [7:0] TYPE_END         = 8'h7f;
	localparam int unsigned HEADER_BYTES    = 4;

	// Field widths of the request and result channels
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TOTLEN_W = 16;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned S_DATA_W = BYTE_W + TOTLEN_W;

	// Outcome of one buffer walk
	typedef enum logic [1:0] {
		REASON_FOUND     = 2'd0,
		REASON_END       = 2'd1,
		REASON_MALFORMED = 2'd2,
		REASON_EXHAUSTED = 2'd3
	} reason_t;

	localparam int unsigned USER_W = 1 + $bits(reason_t);

endpackage
`default_nettype wire

// ----- rtl/core/device_path_filepath_finder_core.sv -----
// Top level of the device-path file-path finder: node walk and result register.
`timescale 1ns / 1ps
`default_nettype none
// The block takes a device-path buffer one byte per request, one request per clock cycle,
// and walks its nodes (type, subtype, 16-bit little-endian length, payload). A request with
// s_tuser high starts a new buffer and supplies its total length; an unfinished buffer is
// then dropped. Each buffer gives exactly one result: a found media/file-path node with the
// offset of its payload, or a not-found with the reason (end node, malformed node length,
// buffer exhausted). The result comes out of a register in the cycle after the deciding byte
// is taken; bytes after the decision are absorbed without effect. Throughput is one byte
// per cycle, set by the position counter and header compare; s_tready falls only while a
// result sits in the output register and the downstream side holds m_tready low.
module device_path_filepath_finder_core #(
	parameter int unsigned LENGTH_BITS = dpfp_pkg::LENGTH_BITS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [7:0] data_byte, [23:8] total_length
	input  wire logic [dpfp_pkg::S_DATA_W-1:0] s_tdata,
	// [0] first_byte
	input  wire logic                         s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [15:0] path_offset
	output logic [dpfp_pkg::OFFSET_W-1:0]     m_tdata,
	// [0] found, [2:1] reason
	output logic [dpfp_pkg::USER_W-1:0]       m_tuser
);
	import dpfp_pkg::*;

	localparam int unsigned LB = LENGTH_BITS;
	// Wide enough for the length field or the counters, whichever is wider
	localparam int unsigned WX = (LB > TOTLEN_W) ? LB : TOTLEN_W;
	// Room for node start plus node length plus a header without overflow
	localparam int unsigned WS = WX + 2;

	// Walk state
	logic [LB-1:0] pos_q, start_q, blen_q;
	logic [7:0]    type_q, sub_q, lenlo_q;
	logic          decided_q;

	// Result register
	logic                res_valid_q;
	logic                res_found_q;
	logic [OFFSET_W-1:0] res_offset_q;
	reason_t             res_reason_q;

	// Combinational walk signals
	logic [BYTE_W-1:0]   data_byte;
	logic [TOTLEN_W-1:0] total_length;
	logic [WX-1:0]       tl_ext;
	logic                accept;
	logic [LB-1:0]       pos_c, start_c, blen_c, rel;
	logic [7:0]          type_c, sub_c, lenlo_c;
	logic [15:0]         node_size;
	logic [WS-1:0]       node_end, next_hdr_end, blen_w, payload_off;
	logic [LB-1:0]       pos_n, start_n;
	logic [7:0]          type_n, sub_n, lenlo_n;
	logic                decided_n;
	logic                emit;
	logic                emit_found;
	reason_t             emit_reason;

	assign data_byte    = s_tdata[BYTE_W-1:0];
	assign total_length = s_tdata[S_DATA_W-1:BYTE_W];
	assign tl_ext       = WX'(total_length);

	// A new request is taken whenever the result register is free or being drained
	assign s_tready = !res_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Decide on the current byte: a first byte restarts the walk from a cleared state
	always_comb begin
		pos_c   = s_tuser ? '0 : pos_q;
		start_c = s_tuser ? '0 : start_q;
		blen_c  = s_tuser ? tl_ext[LB-1:0] : blen_q;
		type_c  = s_tuser ? 8'h00 : type_q;
		sub_c   = s_tuser ? 8'h00 : sub_q;
		lenlo_c = s_tuser ? 8'h00 : lenlo_q;
		rel     = pos_c - start_c;

		node_size    = {data_byte, lenlo_c};
		blen_w       = WS'(blen_c);
		node_end     = WS'(start_c) + WS'(node_size);
		next_hdr_end = node_end + WS'(HEADER_BYTES);
		payload_off  = WS'(start_c) + WS'(HEADER_BYTES);

		pos_n       = pos_c;
		start_n     = start_c;
		type_n      = type_c;
		sub_n       = sub_c;
		lenlo_n     = lenlo_c;
		decided_n   = s_tuser ? 1'b0 : decided_q;
		emit        = 1'b0;
		emit_found  = 1'b0;
		emit_reason = REASON_FOUND;

		if (s_tuser && blen_w < WS'(HEADER_BYTES)) begin
			emit        = 1'b1;
			emit_reason = REASON_EXHAUSTED;
		end else if (s_tuser || !decided_q) begin
			if (rel == LB'(0)) begin
				type_n = data_byte;
			end else if (rel == LB'(1)) begin
				sub_n = data_byte;
			end else if (rel == LB'(2)) begin
				lenlo_n = data_byte;
			end else if (rel == LB'(3)) begin
				if (node_size < 16'(HEADER_BYTES) || node_end > blen_w) begin
					emit        = 1'b1;
					emit_reason = REASON_MALFORMED;
				end else if (type_c == TYPE_MEDIA && sub_c == SUBTYPE_FILEPATH) begin
					emit        = 1'b1;
					emit_found  = 1'b1;
					emit_reason = REASON_FOUND;
				end else if (type_c == TYPE_END && node_size == 16'(HEADER_BYTES)) begin
					emit        = 1'b1;
					emit_reason = REASON_END;
				end else if (next_hdr_end > blen_w) begin
					emit        = 1'b1;
					emit_reason = REASON_EXHAUSTED;
				end else begin
					start_n = node_end[LB-1:0];
				end
			end
			if (!emit) begin
				pos_n = pos_c + LB'(1);
			end
		end
		if (emit) begin
			decided_n = 1'b1;
		end
	end

	// Walk state registers, updated on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			blen_q    <= '0;
			type_q    <= 8'h00;
			sub_q     <= 8'h00;
			lenlo_q   <= 8'h00;
			decided_q <= 1'b1;
		end else if (accept) begin
			pos_q     <= pos_n;
			start_q   <= start_n;
			blen_q    <= blen_c;
			type_q    <= type_n;
			sub_q     <= sub_n;
			lenlo_q   <= lenlo_n;
			decided_q <= decided_n;
		end
	end

	// Result valid flag: set by a deciding byte, cleared once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (accept && emit) || (res_valid_q && !m_tready);
		end
	end

	// Result payload, loaded only when a decision is made
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_found_q  <= emit_found;
			res_offset_q <= emit_found ? payload_off[OFFSET_W-1:0] : '0;
			res_reason_q <= emit_reason;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_offset_q;
	assign m_tuser  = {res_reason_q, res_found_q};

endmodule
`default_nettype wire

// ----- rtl/core/dpfp_checker.sv -----
// Port-level checker for the device-path file-path finder, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module dpfp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [dpfp_pkg::OFFSET_W-1:0] m_tdata,
	input wire logic [dpfp_pkg::USER_W-1:0]   m_tuser
);
	import dpfp_pkg::*;

	// A stalled result keeps its payload until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The found flag agrees with the reason code
	a_found_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == REASON_FOUND)))
		else $error("found flag and reason disagree");

	// A not-found result carries a zero offset
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("offset not zero on a not-found result");

	// An empty result register never stalls the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

endmodule

bind device_path_filepath_finder_core dpfp_checker u_dpfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ----- tb/dpfp_walk_checker.sv -----
// Checker for the device-path file-path finder: predicts each buffer's outcome and compares.
`timescale 1ns / 1ps
module dpfp_walk_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	// [7:0] data_byte, [23:8] total_length
	input  wire logic [dpfp_pkg::S_DATA_W-1:0] s_tdata,
	// [0] first_byte
	input  wire logic                          s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [15:0] path_offset
	input  wire logic [dpfp_pkg::OFFSET_W-1:0] m_tdata,
	// [0] found, [2:1] reason
	input  wire logic [dpfp_pkg::USER_W-1:0]   m_tuser,
	output int                                 fail_count,
	output int                                 outstanding
);
	import dpfp_pkg::*;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
		reason_t             reason;
	} walk_outcome_t;

	// Outcomes still to come out of the block, oldest first.
	walk_outcome_t outcome_q[$];

	// Our own copy of the walk state.
	logic [15:0] walk_pos;
	logic [15:0] node_base;
	logic [15:0] buf_len;
	logic [7:0]  held_type;
	logic [7:0]  held_subtype;
	logic [7:0]  held_len_lo;
	bit          walk_done;

	walk_outcome_t want;
	walk_outcome_t got;
	walk_outcome_t predicted;
	bit            decided_now;

	// Advance the walk by one byte and say whether this byte settles the buffer.
	task automatic walk_byte(input logic [7:0] b, input logic first, input logic [15:0] tlen,
			output bit emitted, output walk_outcome_t res);
		logic [15:0] rel;
		int unsigned node_size;
		int unsigned next_base;
		emitted = 1'b0;
		res = '{found: 1'b0, offset: '0, reason: REASON_FOUND};
		if (first) begin
			buf_len = tlen;
			walk_pos = '0;
			node_base = '0;
			held_type = '0;
			held_subtype = '0;
			held_len_lo = '0;
			walk_done = 1'b0;
		end
		if (first && buf_len < HEADER_BYTES) begin
			// Too short to hold even one header.
			emitted = 1'b1;
			res.reason = REASON_EXHAUSTED;
		end else if (!walk_done) begin
			rel = walk_pos - node_base;
			case (rel)
				16'd0: held_type = b;
				16'd1: held_subtype = b;
				16'd2: held_len_lo = b;
				16'd3: begin
					node_size = 32'({b, held_len_lo});
					if (node_size < HEADER_BYTES || node_base + node_size > buf_len) begin
						emitted = 1'b1;
						res.reason = REASON_MALFORMED;
					end else if (held_type == TYPE_MEDIA && held_subtype == SUBTYPE_FILEPATH) begin
						emitted = 1'b1;
						res.found = 1'b1;
						res.offset = node_base + 16'(HEADER_BYTES);
					end else if (held_type == TYPE_END && node_size == HEADER_BYTES) begin
						emitted = 1'b1;
						res.reason = REASON_END;
					end else begin
						next_base = node_base + node_size;
						if (next_base + HEADER_BYTES > buf_len) begin
							emitted = 1'b1;
							res.reason = REASON_EXHAUSTED;
						end else begin
							node_base = next_base[15:0];
						end
					end
				end
				default: ;
			endcase
			if (!emitted)
				walk_pos = walk_pos + 16'd1;
		end
		if (emitted)
			walk_done = 1'b1;
	endtask

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// Compare results against the oldest prediction, then predict from the accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_pos = '0;
			node_base = '0;
			buf_len = '0;
			held_type = '0;
			held_subtype = '0;
			held_len_lo = '0;
			walk_done = 1'b1;
			outcome_q.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{found: m_tuser[0], offset: m_tdata, reason: reason_t'(m_tuser[2:1])};
				if (outcome_q.size() == 0) begin
					$error("unexpected result: found %0d, path_offset %0d, reason %0d",
						got.found, got.offset, got.reason);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						fail_count++;
					end
					if (got.offset !== want.offset) begin
						$error("path_offset: expected %0d, actual %0d", want.offset, got.offset);
						fail_count++;
					end
					if (got.reason !== want.reason) begin
						$error("reason: expected %0d, actual %0d", want.reason, got.reason);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				walk_byte(s_tdata[7:0], s_tuser, s_tdata[23:8], decided_now, predicted);
				if (decided_now)
					outcome_q.push_back(predicted);
			end
			outstanding = outcome_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench: clock, reset, byte stream stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps
module testbench;
	import dpfp_pkg::*;

	localparam int HOLDOFF_CYCLES = 500;
	localparam int QUIET_LIMIT    = 4000;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_ITEMS    = 300;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OFFSET_W-1:0] m_tdata;
	logic [USER_W-1:0]   m_tuser;

	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit holdoff_req = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// Bytes of the buffer being built, sent in order.
	logic [7:0] path_bytes[$];

	device_path_filepath_finder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	dpfp_walk_checker walk_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Offer one byte from a falling edge and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] tlen);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = first;
		s_tdata = {tlen, b};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic add_node(input logic [7:0] t, input logic [7:0] st, input logic [15:0] len,
			input int unsigned body);
		path_bytes.push_back(t);
		path_bytes.push_back(st);
		path_bytes.push_back(len[7:0]);
		path_bytes.push_back(len[15:8]);
		repeat (body) path_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_junk(input int n);
		repeat (n) path_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Nodes that the walk must step over: near misses on the media and end kinds included.
	task automatic add_skips(input int n);
		logic [7:0]  t;
		logic [7:0]  st;
		logic [15:0] len;
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: t = TYPE_MEDIA;
				1: t = TYPE_END;
				default: t = 8'($urandom_range(0, 255));
			endcase
			st = 8'($urandom_range(0, 255));
			len = 16'($urandom_range(4, 10));
			if (t == TYPE_MEDIA && st == SUBTYPE_FILEPATH)
				st = 8'h05;
			if (t == TYPE_END && len == 16'(HEADER_BYTES))
				len = 16'd5;
			add_node(t, st, len, len - 4);
		end
	endtask

	// Buffer length with a little slack, now and then a very large one.
	function automatic logic [15:0] pick_length(input int unsigned used);
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(used, 65535));
		return 16'(used + $urandom_range(0, 8));
	endfunction

	// Send the built buffer, with the start mark and length on its first byte only.
	task automatic send_path(input logic [15:0] tlen);
		foreach (path_bytes[i])
			send_byte(path_bytes[i], i == 0, (i == 0) ? tlen : 16'($urandom_range(0, 65535)));
		path_bytes.delete();
	endtask

	// One random buffer, shaped so that most of them walk to a real decision.
	task automatic random_buffer();
		int unsigned kind;
		int unsigned start;
		logic [15:0] tlen;
		logic [15:0] len;
		logic [7:0]  st;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			add_skips($urandom_range(0, 3));
			len = 16'($urandom_range(4, 12));
			add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, len, len - 4);
			tlen = pick_length(path_bytes.size());
			add_junk($urandom_range(0, 3));
		end else if (kind < 50) begin
			add_skips($urandom_range(0, 3));
			add_node(TYPE_END, 8'($urandom_range(0, 255)), 16'(HEADER_BYTES), 0);
			tlen = pick_length(path_bytes.size());
			add_junk($urandom_range(0, 3));
		end else if (kind < 65) begin
			// Length below a header, or a node running past the buffer end.
			add_skips($urandom_range(0, 3));
			start = path_bytes.size();
			tlen = 16'(start + $urandom_range(4, 20));
			if ($urandom_range(0, 1))
				len = 16'($urandom_range(0, 3));
			else
				len = 16'($urandom_range(tlen - start + 1, 65535));
			st = $urandom_range(0, 1) ? SUBTYPE_FILEPATH : 8'($urandom_range(0, 255));
			add_node($urandom_range(0, 1) ? TYPE_MEDIA : TYPE_END, st, len, 0);
			add_junk($urandom_range(0, 4));
		end else if (kind < 80) begin
			if ($urandom_range(0, 3) == 0) begin
				add_junk(1);
				tlen = 16'($urandom_range(0, 3));
			end else begin
				add_skips($urandom_range(1, 3));
				tlen = 16'(path_bytes.size() + $urandom_range(0, 3));
			end
			add_junk($urandom_range(0, 3));
		end else if (kind < 90) begin
			// Stop inside a header so that the next start mark cuts the walk short.
			add_skips($urandom_range(0, 2));
			add_junk($urandom_range(1, 3));
			tlen = 16'($urandom_range(path_bytes.size() + 8, 65535));
		end else begin
			add_junk($urandom_range(1, 24));
			if ($urandom_range(0, 9) == 0)
				tlen = 16'($urandom_range(0, 65535));
			else
				tlen = 16'($urandom_range(0, 40));
		end
		send_path(tlen);
	endtask

	// Receiver pacing, with a long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				m_tready = 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end
			m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no handshake on either side.
	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int target;
		@(posedge arst_n);
		@(negedge clk);

		// Bytes before any start mark are ignored.
		repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));

		// Buffers too short for one header.
		for (int n = 0; n < 4; n++) begin
			add_junk(1);
			send_path(16'(n));
		end

		// File-path node as the whole buffer, and inside the largest buffer.
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd4, 0);
		send_path(16'd4);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd8, 4);
		send_path(16'hffff);

		// End node, then an end-type node that is too long to end the walk.
		add_node(TYPE_END, 8'hff, 16'd4, 0);
		add_junk(3);
		send_path(16'd8);
		add_node(TYPE_END, 8'h01, 16'd6, 2);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd4, 0);
		send_path(16'd10);

		// Near misses on type and on subtype before the real one.
		add_node(TYPE_MEDIA, 8'h03, 16'd4, 0);
		add_node(8'h03, SUBTYPE_FILEPATH, 16'd5, 1);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd6, 2);
		send_path(16'd15);

		// Malformed lengths: zero, just under a header, huge, one past the end.
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd0, 0);
		send_path(16'd20);
		add_node(TYPE_END, 8'h00, 16'd3, 0);
		send_path(16'd20);
		add_node(8'h00, 8'h00, 16'hffff, 0);
		send_path(16'hfffe);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd9, 0);
		send_path(16'd8);

		// Too little left after a node, then an exact fit that still has room.
		add_node(8'h01, 8'h02, 16'd4, 0);
		add_junk(2);
		send_path(16'd6);
		add_node(8'h01, 8'h02, 16'd4, 0);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd4, 0);
		send_path(16'd8);

		// Restarts inside a header and inside a payload.
		add_junk(2);
		send_path(16'd100);
		add_node(8'h02, 8'h01, 16'd10, 3);
		send_path(16'd200);
		add_node(TYPE_MEDIA, SUBTYPE_FILEPATH, 16'd4, 0);
		send_path(16'd4);

		// Random buffers under each pacing mix; the first opens with a long receiver hold-off.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					holdoff_req = 1'b1;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_buffer();
		end

		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/dpfp_pkg.sv
rtl/core/device_path_filepath_finder_core.sv
rtl/core/dpfp_checker.sv
tb/dpfp_walk_checker.sv
tb/testbench.sv
